// ===== rtl/tslq_pkg.sv =====
// Shared types and constants for the timed scene launch queue.
// No dependencies; imported by the registry and the top module.
package tslq_pkg;

    localparam int ID_W    = 16;
    localparam int FRAME_W = 48;

    // Scene id reported when the registry holds no entries.
    localparam logic [ID_W-1:0] NO_SCENE = '1;

    typedef enum logic [1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_PROCESS  = 2'd1,
        OP_SWITCH   = 2'd2,
        OP_REGISTER = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QRD,
        S_EXEC,
        S_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        R_IDLE,
        R_SCAN,
        R_F1,
        R_F2,
        R_F3,
        R_DONE
    } t_rstate;

    // Command from the sequencer to the registry unit.
    typedef struct packed {
        logic            start;
        logic            wr;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] target;
    } t_reg_cmd;

    // Response from the registry unit.
    typedef struct packed {
        logic            done;
        logic            ok;
        logic [ID_W-1:0] following;
        logic [ID_W-1:0] preceding;
    } t_reg_rsp;

endpackage

// ===== rtl/tslq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tslq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tslq_registry.sv =====
// Scene registry: append store plus a sequential first-match scan that
// reports the neighbors of the target scene. Depends on tslq_pkg, tslq_ram.
module tslq_registry
    import tslq_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_reg_cmd i_cmd,
    output t_reg_rsp o_rsp
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(SLOTS + 1);

    t_rstate         r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic [FW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_pidx, n_pidx;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_pos, n_pos;
    logic            r_found, n_found;
    logic [ID_W-1:0] r_target, n_target;
    logic [ID_W-1:0] r_follow, n_follow;
    logic [ID_W-1:0] r_prec, n_prec;
    logic            r_ok, n_ok;

    logic            we;
    logic [AW-1:0]   raddr;
    logic [ID_W-1:0] rdata;
    logic [FW-1:0]   fill_m1;
    logic [FW:0]     pos_p1;
    logic [AW-1:0]   follow_addr;
    logic [AW-1:0]   prec_addr;

    tslq_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_cmd.id),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Neighbor slots; a miss falls back to first and last entries.
    always_comb begin
        fill_m1     = r_fill - FW'(1);
        pos_p1      = (FW + 1)'(r_pos) + (FW + 1)'(1);
        follow_addr = '0;
        prec_addr   = fill_m1[AW-1:0];
        if (r_found) begin
            follow_addr = (pos_p1 == (FW + 1)'(r_fill)) ? '0 : pos_p1[AW-1:0];
            prec_addr   = (r_pos == '0) ? fill_m1[AW-1:0] : r_pos - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_pend   <= n_pend;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_target <= n_target;
        r_follow <= n_follow;
        r_prec   <= n_prec;
        r_ok     <= n_ok;
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pend   = r_pend;
        n_pos    = r_pos;
        n_found  = r_found;
        n_target = r_target;
        n_follow = r_follow;
        n_prec   = r_prec;
        n_ok     = r_ok;
        we       = 1'b0;
        raddr    = r_idx[AW-1:0];
        unique case (r_state)
            R_IDLE: begin
                if (i_cmd.start) begin
                    n_target = i_cmd.target;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_found  = 1'b0;
                    n_ok     = 1'b0;
                    if (i_cmd.wr && (r_fill < FW'(SLOTS))) begin
                        we     = 1'b1;
                        n_fill = r_fill + FW'(1);
                        n_ok   = 1'b1;
                    end
                    if (n_fill == '0) begin
                        n_follow = NO_SCENE;
                        n_prec   = NO_SCENE;
                        n_state  = R_DONE;
                    end else begin
                        n_state  = R_SCAN;
                    end
                end
            end
            R_SCAN: begin
                // one read issued and one compare made per cycle
                if (r_pend && (rdata == r_target)) begin
                    n_found = 1'b1;
                    n_pos   = r_pidx;
                    n_state = R_F1;
                end else if (r_pend && (FW'(r_pidx) == fill_m1)) begin
                    n_state = R_F1;
                end else begin
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + FW'(1);
                    n_pend = 1'b1;
                end
            end
            R_F1: begin
                raddr   = follow_addr;
                n_state = R_F2;
            end
            R_F2: begin
                raddr    = prec_addr;
                n_follow = rdata;
                n_state  = R_F3;
            end
            R_F3: begin
                n_prec  = rdata;
                n_state = R_DONE;
            end
            R_DONE: begin
                n_state = R_IDLE;
            end
            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    assign o_rsp.done      = (r_state == R_DONE);
    assign o_rsp.ok        = r_ok;
    assign o_rsp.following = r_follow;
    assign o_rsp.preceding = r_prec;

endmodule

// ===== rtl/timed_scene_launch_queue_top.sv =====
// Timed scene launch queue: frame-gated launch FIFO, scene switch, registry.
// Steps in order: input capture, queue head read (S_QRD), execution (S_EXEC),
// registry scan (S_WAIT), result held (S_OUT) until taken; the scan stops at
// the first match or the last entry. One item at a time; input tready is low
// until the result transaction completes.
// Reset (synchronous, active low): queue and registry empty, scene 0, flag 0.
module timed_scene_launch_queue_top
    import tslq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 8,
    parameter int REGISTRY_SLOTS = 16,
    localparam int QFW    = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_W  = ((50 + QFW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // slave side
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [63:0]      i_s_axis_tdata,  // scene_id[15:0], frame_number[63:16]
    input  logic [1:0]       i_s_axis_tuser,  // operation[1:0]
    // master side
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // ok[0], current_scene[16:1], scene_changed[17], following_scene[33:18],
    // preceding_scene[49:34], pending_count[50+QFW-1:50], zero fill above
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QW  = ID_W + FRAME_W;

    t_state             r_state, n_state;
    t_op                r_op;
    logic [ID_W-1:0]    r_id;
    logic [FRAME_W-1:0] r_frame;
    logic [QAW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [QAW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [QFW-1:0]     r_fill, n_fill;
    logic [ID_W-1:0]    r_active, n_active;
    logic               r_changed, n_changed;
    logic               r_ok, n_ok;

    logic               q_we;
    logic [QW-1:0]      q_rdata;
    logic [ID_W-1:0]    head_id;
    logic [FRAME_W-1:0] head_frame;
    logic               head_due;
    logic [ID_W-1:0]    sw_id;
    logic               sw_valid;
    t_reg_cmd           reg_cmd;
    t_reg_rsp           reg_rsp;

    tslq_ram #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_wr_ptr),
        .i_wdata ({r_id, r_frame}),
        .i_raddr (r_rd_ptr),
        .o_rdata (q_rdata)
    );

    tslq_registry #(
        .SLOTS (REGISTRY_SLOTS)
    ) u_registry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (reg_cmd),
        .o_rsp   (reg_rsp)
    );

    assign head_id    = q_rdata[QW-1:FRAME_W];
    assign head_frame = q_rdata[FRAME_W-1:0];
    // single frame compare: head launch due once its frame is at or below the given frame
    assign head_due   = (r_fill != '0) && (head_frame <= r_frame);
    assign sw_id      = (r_op == OP_PROCESS) ? head_id : r_id;
    // switch only to a non-negative id that differs from the current scene
    assign sw_valid   = !sw_id[ID_W-1] && (sw_id != r_active);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
            r_active  <= '0;
            r_changed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_fill    <= n_fill;
            r_active  <= n_active;
            r_changed <= n_changed;
        end
        r_ok <= n_ok;
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_op    <= t_op'(i_s_axis_tuser);
            r_id    <= i_s_axis_tdata[15:0];
            r_frame <= i_s_axis_tdata[63:16];
        end
    end

    always_comb begin
        n_state        = r_state;
        n_rd_ptr       = r_rd_ptr;
        n_wr_ptr       = r_wr_ptr;
        n_fill         = r_fill;
        n_active       = r_active;
        n_changed      = r_changed;
        n_ok           = r_ok;
        q_we           = 1'b0;
        reg_cmd.start  = 1'b0;
        reg_cmd.wr     = (r_op == OP_REGISTER);
        reg_cmd.id     = r_id;
        reg_cmd.target = r_active;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                // queue head read in flight
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_ok = 1'b0;
                unique case (r_op)
                    OP_ENQUEUE: begin
                        if (r_fill < QFW'(QUEUE_DEPTH)) begin
                            q_we     = 1'b1;
                            n_wr_ptr = (r_wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0
                                                                           : r_wr_ptr + QAW'(1);
                            n_fill   = r_fill + QFW'(1);
                            n_ok     = 1'b1;
                        end
                    end
                    OP_PROCESS: begin
                        if (head_due) begin
                            n_rd_ptr = (r_rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0
                                                                           : r_rd_ptr + QAW'(1);
                            n_fill   = r_fill - QFW'(1);
                            if (sw_valid) begin
                                n_active  = sw_id;
                                n_changed = 1'b1;
                                n_ok      = 1'b1;
                            end
                        end
                    end
                    OP_SWITCH: begin
                        if (sw_valid) begin
                            n_active  = sw_id;
                            n_changed = 1'b1;
                            n_ok      = 1'b1;
                        end
                    end
                    OP_REGISTER: begin
                        // ok comes back from the registry unit
                    end
                    default: begin
                    end
                endcase
                // registry looks up the scene as it stands after this item
                reg_cmd.target = n_active;
                reg_cmd.start  = 1'b1;
                n_state        = S_WAIT;
            end
            S_WAIT: begin
                if (reg_rsp.done) begin
                    if (r_op == OP_REGISTER) begin
                        n_ok = reg_rsp.ok;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = OUT_W'({r_fill, reg_rsp.preceding, reg_rsp.following,
                                     r_changed, r_active, r_ok});

    // Queue never holds more launches than its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= QFW'(QUEUE_DEPTH))
        else $error("launch queue fill above depth");

    // One item at a time: input never taken while a result is held.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while result pending");

    // Registry completion only while the sequencer waits for it.
    a_reg_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reg_rsp.done |-> (r_state == S_WAIT))
        else $error("registry done outside wait state");

    // Queue state is untouched while a result waits to be taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && $past(o_m_axis_tvalid)) |-> ($stable(r_fill) && $stable(r_active)))
        else $error("state changed during result hold");

endmodule
